// File: rtl/smx_pkg.sv
// Shared types, constants and dispatch function for the stack machine execute block.
// Used by smx_useq and stack_machine_execute; depends on nothing else.
`default_nettype none

package smx_pkg;

    // Sizing; jump targets wrap by keeping the low address bits, so the
    // program depth stays a power of two
    localparam int STACK_DEPTH   = 8;
    localparam int PROGRAM_DEPTH = 256;
    localparam int SP_W          = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W         = $clog2(STACK_DEPTH);
    localparam int IP_W          = $clog2(PROGRAM_DEPTH);
    localparam int UPC_W         = 4;

    typedef logic [2:0]       t_cmd;
    typedef logic [1:0]       t_err;
    typedef logic [3:0]       t_dp_op;
    typedef logic [2:0]       t_cond;
    typedef logic [UPC_W-1:0] t_upc;

    // Instruction codes
    localparam t_cmd CMD_START = 3'd0;
    localparam t_cmd CMD_HLT   = 3'd1;
    localparam t_cmd CMD_PUSH  = 3'd2;
    localparam t_cmd CMD_ADD   = 3'd3;
    localparam t_cmd CMD_POP   = 3'd4;
    localparam t_cmd CMD_JMP   = 3'd5;
    localparam t_cmd CMD_SUM   = 3'd6;
    localparam t_cmd CMD_CMP   = 3'd7;

    // Error codes
    localparam t_err ERR_NONE      = 2'd0;
    localparam t_err ERR_POP_UNF   = 2'd1;
    localparam t_err ERR_PUSH_OVF  = 2'd2;
    localparam t_err ERR_ADD_EMPTY = 2'd3;

    // Datapath operations selected by the control word
    localparam t_dp_op DP_NOP      = 4'd0;
    localparam t_dp_op DP_CLEAR    = 4'd1;
    localparam t_dp_op DP_HALT     = 4'd2;
    localparam t_dp_op DP_PUSH     = 4'd3;
    localparam t_dp_op DP_POP      = 4'd4;
    localparam t_dp_op DP_SUM      = 4'd5;
    localparam t_dp_op DP_CMP      = 4'd6;
    localparam t_dp_op DP_ADD_INIT = 4'd7;
    localparam t_dp_op DP_ADD_ACC  = 4'd8;
    localparam t_dp_op DP_ADD_DONE = 4'd9;
    localparam t_dp_op DP_ADD_ERR  = 4'd10;
    localparam t_dp_op DP_JMP      = 4'd11;

    // Jump conditions
    localparam t_cond COND_NEVER  = 3'd0;
    localparam t_cond COND_ALWAYS = 3'd1;
    localparam t_cond COND_EMPTY  = 3'd2;
    localparam t_cond COND_WALK   = 3'd3;

    // Microprogram entry points and labels
    localparam t_upc U_START    = 4'd0;
    localparam t_upc U_HLT      = 4'd1;
    localparam t_upc U_PUSH     = 4'd2;
    localparam t_upc U_POP      = 4'd3;
    localparam t_upc U_SUM      = 4'd4;
    localparam t_upc U_CMP      = 4'd5;
    localparam t_upc U_IDLEH    = 4'd6;
    localparam t_upc U_ADD      = 4'd7;
    localparam t_upc U_ADD_LOOP = 4'd8;
    localparam t_upc U_ADD_DONE = 4'd9;
    localparam t_upc U_ADD_ERR  = 4'd10;
    localparam t_upc U_JMP      = 4'd11;

    typedef struct packed {
        t_dp_op op;
        t_cond  cond;
        t_upc   target;
        logic   done;
    } t_cword;

    typedef struct packed {
        logic empty;
        logic walk_more;
    } t_dp_flags;

    // Entry point for an accepted item; a halted machine only echoes its state
    function automatic t_upc smx_entry(input t_cmd cmd, input logic halted);
        t_upc e;
        unique case (cmd)
            CMD_START: e = U_START;
            CMD_HLT:   e = U_HLT;
            CMD_PUSH:  e = U_PUSH;
            CMD_ADD:   e = U_ADD;
            CMD_POP:   e = U_POP;
            CMD_JMP:   e = U_JMP;
            CMD_SUM:   e = U_SUM;
            CMD_CMP:   e = U_CMP;
        endcase
        if (halted) begin
            e = U_IDLEH;
        end
        return e;
    endfunction

endpackage

`default_nettype wire

// File: rtl/smx_useq.sv
// Microcode sequencer: step counter, control store and conditional jumps.
// Depends on smx_pkg for the control word, flags and microprogram labels.
`default_nettype none

module smx_useq
    import smx_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_start,
    input  wire t_upc      i_entry,
    input  wire t_dp_flags i_flags,
    input  wire logic      i_stall,
    output logic           o_busy,
    output t_cword         o_cw
);

    // Control store
    function automatic t_cword smx_rom(input t_upc a);
        t_cword w;
        unique case (a)
            U_START:    w = '{op: DP_CLEAR,    cond: COND_NEVER, target: '0,         done: 1'b1};
            U_HLT:      w = '{op: DP_HALT,     cond: COND_NEVER, target: '0,         done: 1'b1};
            U_PUSH:     w = '{op: DP_PUSH,     cond: COND_NEVER, target: '0,         done: 1'b1};
            U_POP:      w = '{op: DP_POP,      cond: COND_NEVER, target: '0,         done: 1'b1};
            U_SUM:      w = '{op: DP_SUM,      cond: COND_NEVER, target: '0,         done: 1'b1};
            U_CMP:      w = '{op: DP_CMP,      cond: COND_NEVER, target: '0,         done: 1'b1};
            U_IDLEH:    w = '{op: DP_NOP,      cond: COND_NEVER, target: '0,         done: 1'b1};
            U_ADD:      w = '{op: DP_ADD_INIT, cond: COND_EMPTY, target: U_ADD_ERR,  done: 1'b0};
            U_ADD_LOOP: w = '{op: DP_ADD_ACC,  cond: COND_WALK,  target: U_ADD_LOOP, done: 1'b0};
            U_ADD_DONE: w = '{op: DP_ADD_DONE, cond: COND_NEVER, target: '0,         done: 1'b1};
            U_ADD_ERR:  w = '{op: DP_ADD_ERR,  cond: COND_NEVER, target: '0,         done: 1'b1};
            U_JMP:      w = '{op: DP_JMP,      cond: COND_NEVER, target: '0,         done: 1'b1};
            default:    w = '{op: DP_NOP,      cond: COND_NEVER, target: '0,         done: 1'b1};
        endcase
        return w;
    endfunction

    logic   r_busy, n_busy;
    t_upc   r_upc, n_upc;
    logic   w_take;
    t_cword w_cw;

    assign w_cw   = smx_rom(r_upc);
    assign o_cw   = w_cw;
    assign o_busy = r_busy;

    always_comb begin
        unique case (w_cw.cond)
            COND_NEVER:  w_take = 1'b0;
            COND_ALWAYS: w_take = 1'b1;
            COND_EMPTY:  w_take = i_flags.empty;
            COND_WALK:   w_take = i_flags.walk_more;
            default:     w_take = 1'b0;
        endcase
    end

    always_comb begin
        n_busy = r_busy;
        n_upc  = r_upc;
        if (!r_busy && i_start) begin
            n_busy = 1'b1;
            n_upc  = i_entry;
        end else if (r_busy && !i_stall) begin
            if (w_cw.done) begin
                n_busy = 1'b0;
            end else if (w_take) begin
                n_upc = w_cw.target;
            end else begin
                n_upc = r_upc + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_upc  <= '0;
        end else begin
            r_busy <= n_busy;
            r_upc  <= n_upc;
        end
    end

endmodule

`default_nettype wire

// File: rtl/stack_machine_execute.sv
// Stack machine execute unit: datapath, machine state and result channel.
// Depends on smx_pkg and on smx_useq, which sequences each instruction.
//
// Usage. Each input item is one decoded instruction (i_command, i_operand),
// taken when i_in_valid and o_in_ready are both high. Each item gives exactly
// one result item (next fetch address, stack count, accumulator, compare sum,
// halt flag, error code), offered on o_out_valid until i_out_ready takes it.
// Microprogram steps from acceptance to o_out_valid:
//   START, HLT, PUSH, POP, SUM, JMP, CMP and any item once halted: the done step
//   ADD: an init step, accumulate steps that walk the stack and a done step;
//   on an empty stack the init step goes to the error step instead
// The steps are set by the microprogram: ADD walks the stack through one
// adder, one entry per step. o_in_ready is high whenever no instruction is in
// flight, so a new item may be taken while a finished result still waits; a
// stalled receiver holds the final step of that next item, and the visible
// state, until the waiting result is taken. Synchronous reset clears the
// stack count, pointers, accumulator, compare sum and halt flag and drops
// any result.
`default_nettype none

module stack_machine_execute
    import smx_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [2:0]  i_command,
    input  wire logic [31:0] i_operand,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [7:0]       o_next_ip,
    output logic [3:0]       o_stack_count,
    output logic [31:0]      o_accum,
    output logic [31:0]      o_compare_sum,
    output logic             o_halted,
    output logic [1:0]       o_error
);

    // Visible machine state
    logic [31:0]      r_stack [STACK_DEPTH];
    logic [SP_W-1:0]  r_sp, n_sp;
    logic [IP_W-1:0]  r_ip, n_ip;
    logic [31:0]      r_acc, n_acc;
    logic [31:0]      r_cmp, n_cmp;
    logic             r_halt, n_halt;
    t_err             r_err, n_err;
    logic             r_out_valid, n_out_valid;

    // Working registers for multi-step instructions
    logic [31:0]      r_operand;
    logic [31:0]      r_total, n_total;
    logic [SP_W-1:0]  r_walk, n_walk;

    // Stack write port
    logic             w_stk_we;
    logic [IDX_W-1:0] w_stk_idx;
    logic [31:0]      w_stk_wd;

    // Sequencer link
    logic      w_busy;
    t_cword    w_cw;
    t_dp_flags w_flags;
    logic      w_accept;
    logic      w_stall;
    logic      w_fire;

    // Datapath helpers
    logic [IP_W-1:0] w_ip_inc;
    logic [31:0]     w_jmp_raw;
    logic [31:0]     w_walk_rd;
    logic [SP_W:0]   w_walk_inc;
    logic [IP_W+7:0] w_ip_ext;
    logic [SP_W+3:0] w_sp_ext;

    assign o_in_ready = !w_busy;
    assign w_accept   = i_in_valid && o_in_ready;
    // hold the last step of an item while the previous result waits
    assign w_stall    = w_cw.done && r_out_valid && !i_out_ready;
    assign w_fire     = w_busy && !w_stall;

    assign w_flags.empty     = (r_sp == '0);
    assign w_walk_inc        = {1'b0, r_walk} + 1'b1;
    assign w_flags.walk_more = (w_walk_inc < {1'b0, r_sp});

    smx_useq u_useq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_accept),
        .i_entry (smx_entry(i_command, r_halt)),
        .i_flags (w_flags),
        .i_stall (w_stall),
        .o_busy  (w_busy),
        .o_cw    (w_cw)
    );

    // advance the fetch address, wrapping at the program depth
    assign w_ip_inc = (r_ip == IP_W'(PROGRAM_DEPTH - 1)) ? '0 : r_ip + 1'b1;

    // jump target is operand minus one; keeping the low address bits wraps it
    assign w_jmp_raw  = r_operand - 32'd1;

    assign w_walk_rd = r_stack[r_walk[IDX_W-1:0]];

    always_comb begin
        n_sp        = r_sp;
        n_ip        = r_ip;
        n_acc       = r_acc;
        n_cmp       = r_cmp;
        n_halt      = r_halt;
        n_err       = r_err;
        n_total     = r_total;
        n_walk      = r_walk;
        w_stk_we    = 1'b0;
        w_stk_idx   = r_sp[IDX_W-1:0];
        w_stk_wd    = r_operand;
        n_out_valid = (i_out_ready) ? 1'b0 : r_out_valid;

        if (w_fire) begin
            if (w_cw.done) begin
                n_err       = ERR_NONE;
                n_out_valid = 1'b1;
            end
            unique case (w_cw.op)
                DP_NOP: begin
                end
                DP_CLEAR: begin
                    n_sp  = '0;
                    n_acc = '0;
                    n_ip  = w_ip_inc;
                end
                DP_HALT: begin
                    n_sp   = '0;
                    n_halt = 1'b1;
                    n_ip   = w_ip_inc;
                end
                DP_PUSH: begin
                    if (r_sp >= SP_W'(STACK_DEPTH)) begin
                        n_err = ERR_PUSH_OVF;
                    end else begin
                        w_stk_we = 1'b1;
                        n_sp     = r_sp + 1'b1;
                    end
                    n_ip = w_ip_inc;
                end
                DP_POP: begin
                    if (r_sp == '0) begin
                        n_err = ERR_POP_UNF;
                    end else begin
                        n_sp = r_sp - 1'b1;
                    end
                    n_ip = w_ip_inc;
                end
                DP_SUM: begin
                    n_cmp = r_cmp + r_acc;
                    n_ip  = w_ip_inc;
                end
                DP_CMP: begin
                    if ($signed(r_cmp) >= $signed(r_operand)) begin
                        n_halt = 1'b1;
                    end else begin
                        n_ip = w_ip_inc;
                    end
                end
                DP_ADD_INIT: begin
                    n_total = r_stack[0];
                    n_walk  = SP_W'(1);
                end
                DP_ADD_ACC: begin
                    if (r_walk < r_sp) begin
                        n_total = r_total + w_walk_rd;
                        n_walk  = w_walk_inc[SP_W-1:0];
                    end
                end
                DP_ADD_DONE: begin
                    w_stk_we  = 1'b1;
                    w_stk_idx = '0;
                    w_stk_wd  = r_total;
                    n_acc     = r_total;
                    n_sp      = SP_W'(1);
                    n_ip      = w_ip_inc;
                end
                DP_ADD_ERR: begin
                    n_err = ERR_ADD_EMPTY;
                    n_ip  = w_ip_inc;
                end
                DP_JMP: begin
                    n_ip = w_jmp_raw[IP_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp        <= '0;
            r_ip        <= '0;
            r_acc       <= '0;
            r_cmp       <= '0;
            r_halt      <= 1'b0;
            r_err       <= ERR_NONE;
            r_out_valid <= 1'b0;
        end else begin
            r_sp        <= n_sp;
            r_ip        <= n_ip;
            r_acc       <= n_acc;
            r_cmp       <= n_cmp;
            r_halt      <= n_halt;
            r_err       <= n_err;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload and working registers: entries above the stack count are never read
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_operand <= i_operand;
        end
        if (w_stk_we) begin
            r_stack[w_stk_idx] <= w_stk_wd;
        end
        r_total  <= n_total;
        r_walk   <= n_walk;
    end

    // Result fields come straight from the state, which holds while a result waits
    assign w_ip_ext      = {8'b0, r_ip};
    assign w_sp_ext      = {4'b0, r_sp};
    assign o_out_valid   = r_out_valid;
    assign o_next_ip     = w_ip_ext[7:0];
    assign o_stack_count = w_sp_ext[3:0];
    assign o_accum       = r_acc;
    assign o_compare_sum = r_cmp;
    assign o_halted      = r_halt;
    assign o_error       = r_err;

    a_sp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= SP_W'(STACK_DEPTH))
        else $error("stack count beyond depth");

    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halt |=> r_halt)
        else $error("halt released without reset");

    a_done_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && w_cw.done) |=> r_out_valid)
        else $error("finished item produced no result");

    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_err == ERR_PUSH_OVF) |-> (r_sp == SP_W'(STACK_DEPTH)))
        else $error("overflow reported on a stack that is not full");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> w_busy)
        else $error("accepted item not started");

endmodule

`default_nettype wire

// File: tb/tb_stack_machine_execute.sv
`timescale 1ns / 1ps
// Self-checking bench for stack_machine_execute: mirrors the machine state in SV
// and checks each result item field by field. Depends on smx_pkg and the RTL.

module tb_stack_machine_execute;
    import smx_pkg::*;

    // One result item as the block reports it
    typedef struct {
        logic [7:0]  next_ip;
        logic [3:0]  stack_count;
        logic [31:0] accum;
        logic [31:0] compare_sum;
        logic        halted;
        t_err        err_code;
    } t_exec_result;

    localparam logic [31:0] INT_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] INT_MIN = 32'h8000_0000;

    logic        i_clk     = 1'b0;
    logic        i_rst_n   = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    t_cmd        command   = CMD_START;
    logic [31:0] operand   = 32'd0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  next_ip;
    logic [3:0]  stack_count;
    logic [31:0] accum;
    logic [31:0] compare_sum;
    logic        halted;
    logic [1:0]  err_code;

    // Shadow of the machine state, advanced once per accepted item
    logic [31:0] shadow_stack [STACK_DEPTH];
    int unsigned shadow_depth;
    int unsigned shadow_ip;
    logic [31:0] shadow_acc;
    logic [31:0] shadow_cmp;
    bit          shadow_halted;

    t_exec_result exec_results_due[$];

    int mismatches   = 0;
    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int rx_hold_len  = 0;
    int rx_hold_reqs = 0;
    int rx_hold_seen = 0;
    int rx_hold_left = 0;

    stack_machine_execute u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_valid),
        .o_in_ready    (in_ready),
        .i_command     (command),
        .i_operand     (operand),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_next_ip     (next_ip),
        .o_stack_count (stack_count),
        .o_accum       (accum),
        .o_compare_sum (compare_sum),
        .o_halted      (halted),
        .o_error       (err_code)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop well beyond the slowest legal run
    initial begin
        #3_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // Execute one instruction on the shadow state and return what the block must report
    function automatic t_exec_result predict_exec(input t_cmd c, input logic [31:0] v);
        t_exec_result r;
        t_err         err;
        logic [31:0]  total;
        int           i;
        err = ERR_NONE;
        if (!shadow_halted) begin
            case (c)
                CMD_START: begin
                    foreach (shadow_stack[i]) shadow_stack[i] = '0;
                    shadow_depth = 0;
                    shadow_acc   = '0;
                    shadow_ip    = (shadow_ip + 1) % PROGRAM_DEPTH;
                end
                CMD_HLT: begin
                    foreach (shadow_stack[i]) shadow_stack[i] = '0;
                    shadow_depth  = 0;
                    shadow_halted = 1'b1;
                    shadow_ip     = (shadow_ip + 1) % PROGRAM_DEPTH;
                end
                CMD_PUSH: begin
                    if (shadow_depth >= STACK_DEPTH) begin
                        err = ERR_PUSH_OVF;
                    end else begin
                        shadow_stack[shadow_depth] = v;
                        shadow_depth++;
                    end
                    shadow_ip = (shadow_ip + 1) % PROGRAM_DEPTH;
                end
                CMD_ADD: begin
                    if (shadow_depth == 0) begin
                        err = ERR_ADD_EMPTY;
                    end else begin
                        total = '0;
                        for (i = 0; i < shadow_depth; i++) total += shadow_stack[i];
                        shadow_stack[0] = total;
                        shadow_acc      = total;
                        shadow_depth    = 1;
                    end
                    shadow_ip = (shadow_ip + 1) % PROGRAM_DEPTH;
                end
                CMD_POP: begin
                    if (shadow_depth == 0) begin
                        err = ERR_POP_UNF;
                    end else begin
                        shadow_depth--;
                    end
                    shadow_ip = (shadow_ip + 1) % PROGRAM_DEPTH;
                end
                CMD_JMP: begin
                    // target is operand minus one, taken unsigned, then wrapped
                    shadow_ip = 32'(v - 32'd1) % 32'(PROGRAM_DEPTH);
                end
                CMD_SUM: begin
                    shadow_cmp += shadow_acc;
                    shadow_ip = (shadow_ip + 1) % PROGRAM_DEPTH;
                end
                CMD_CMP: begin
                    // halt holds the address of the CMP itself
                    if ($signed(shadow_cmp) >= $signed(v)) begin
                        shadow_halted = 1'b1;
                    end else begin
                        shadow_ip = (shadow_ip + 1) % PROGRAM_DEPTH;
                    end
                end
            endcase
        end
        r.next_ip     = 8'(shadow_ip);
        r.stack_count = 4'(shadow_depth);
        r.accum       = shadow_acc;
        r.compare_sum = shadow_cmp;
        r.halted      = shadow_halted;
        r.err_code    = err;
        return r;
    endfunction

    // Geometric idle run, capped so a phase never stalls for ever
    function automatic int idle_len(input int pct);
        int n;
        n = 0;
        while (n < 40 && $urandom_range(99) < pct) n++;
        return n;
    endfunction

    // Operand biased towards the corners of the signed range
    function automatic logic [31:0] pick_value();
        logic [31:0] v;
        v = $urandom;
        if ($urandom_range(7) == 0) begin
            case ($urandom_range(4))
                0: v = 32'd0;
                1: v = 32'd1;
                2: v = 32'hFFFF_FFFF;
                3: v = INT_MAX;
                default: v = INT_MIN;
            endcase
        end
        return v;
    endfunction

    // CMP limit strictly above the compare sum, so the machine keeps running
    function automatic logic [31:0] cmp_limit_above();
        longint lo;
        longint span;
        lo   = longint'($signed(shadow_cmp)) + 1;
        span = 64'sd2147483647 - lo + 1;
        if ($urandom_range(3) == 0) begin
            return 32'(lo);
        end
        return 32'(lo + longint'({$urandom, $urandom} % span));
    endfunction

    // Offer one item at the falling edge and hold it until the block takes it
    task automatic send_instr(input t_cmd c, input logic [31:0] v);
        int gap;
        gap = idle_len(tx_idle_pct);
        @(negedge i_clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_valid <= 1'b1;
        command  <= c;
        operand  <= v;
        do @(posedge i_clk); while (!in_ready);
        exec_results_due.insert(exec_results_due.size(), predict_exec(c, v));
    endtask

    // Drop valid and wait until every result due has been taken
    task automatic wait_results_drained();
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (exec_results_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("%0t ns: %s expected %h, got %h", $time, name, want, got);
            end
        end
    endtask

    // Receiver: random stalls, or a requested hold-off counted down here
    always @(negedge i_clk) begin
        if (rx_hold_reqs != rx_hold_seen) begin
            rx_hold_seen = rx_hold_reqs;
            rx_hold_left = rx_hold_len;
        end
        if (rx_hold_left > 0) begin
            out_ready <= 1'b0;
            rx_hold_left = rx_hold_left - 1;
        end else begin
            out_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Result checker: every taken item must match the oldest one due
    always @(posedge i_clk) begin
        t_exec_result want;
        if (i_rst_n && out_valid && out_ready) begin
            if (exec_results_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t ns: result item with none due", $time);
                end
            end else begin
                want = exec_results_due.pop_front();
                check_field("next_ip",     32'(want.next_ip),     32'(next_ip));
                check_field("stack_count", 32'(want.stack_count), 32'(stack_count));
                check_field("accum",       want.accum,            accum);
                check_field("compare_sum", want.compare_sum,      compare_sum);
                check_field("halted",      32'(want.halted),      32'(halted));
                check_field("error",       32'(want.err_code),    32'(err_code));
            end
        end
    end

    // Every command but HLT, each error case, value extremes, address wrap
    task automatic test_directed_ops();
        int k;
        send_instr(CMD_START, 32'd0);
        send_instr(CMD_POP,   32'd0);      // underflow on empty stack
        send_instr(CMD_ADD,   32'd0);      // add on empty stack
        send_instr(CMD_PUSH,  INT_MAX);
        send_instr(CMD_PUSH,  INT_MIN);
        send_instr(CMD_PUSH,  32'hFFFF_FFFF);
        send_instr(CMD_PUSH,  32'd1);
        for (k = 0; k < STACK_DEPTH - 4; k++) send_instr(CMD_PUSH, $urandom);
        send_instr(CMD_PUSH,  32'hA5A5_5A5A); // overflow on full stack
        send_instr(CMD_ADD,   32'd0);         // sum of a full stack
        send_instr(CMD_SUM,   32'd0);
        send_instr(CMD_CMP,   cmp_limit_above());
        send_instr(CMD_JMP,   32'd0);         // target wraps to the top address
        send_instr(CMD_POP,   32'd0);         // ip wraps back to zero
        send_instr(CMD_JMP,   32'd1);
        send_instr(CMD_POP,   32'd0);
        wait_results_drained();
    endtask

    // Long receiver hold-off while items keep coming: the block must stall its input
    task automatic test_backpressure();
        int k;
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        wait_results_drained();
        rx_hold_len  = 80;
        rx_hold_reqs = rx_hold_reqs + 1;
        for (k = 0; k < 10; k++) begin
            send_instr(($urandom_range(2) == 0) ? CMD_ADD : CMD_PUSH, pick_value());
        end
        wait_results_drained();
    endtask

    // Random program: mostly running code with push bursts, errors arise naturally
    task automatic test_random_program(input int tx_pct, input int rx_pct, input int count);
        int   n;
        int   burst;
        int   r;
        t_cmd c;
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        n = 0;
        while (n < count) begin
            if ($urandom_range(9) == 0) begin
                // fill the stack towards overflow
                burst = $urandom_range(4, 10);
                repeat (burst) send_instr(CMD_PUSH, pick_value());
                n += burst;
            end else begin
                r = $urandom_range(99);
                if (r < 5)       c = CMD_START;
                else if (r < 35) c = CMD_PUSH;
                else if (r < 50) c = CMD_POP;
                else if (r < 65) c = CMD_ADD;
                else if (r < 77) c = CMD_SUM;
                else if (r < 87) c = CMD_CMP;
                else             c = CMD_JMP;
                // no limit lies above the top value, so skip CMP there
                if (c == CMD_CMP && shadow_cmp == INT_MAX) c = CMD_JMP;
                send_instr(c, (c == CMD_CMP) ? cmp_limit_above() : pick_value());
                n++;
            end
        end
        wait_results_drained();
    endtask

    // Halt the machine (HLT, or CMP on an equal limit), then check it ignores all commands
    task automatic test_halt();
        int k;
        tx_idle_pct  = 38;
        rx_stall_pct = 38;
        send_instr(CMD_PUSH, pick_value());
        if ($urandom_range(1) == 1) begin
            send_instr(CMD_HLT, pick_value());
        end else begin
            send_instr(CMD_CMP, shadow_cmp);
        end
        for (k = 0; k < 8; k++) send_instr(t_cmd'(k), pick_value());
        wait_results_drained();
    endtask

    initial begin
        foreach (shadow_stack[k]) shadow_stack[k] = '0;
        shadow_depth  = 0;
        shadow_ip     = 0;
        shadow_acc    = '0;
        shadow_cmp    = '0;
        shadow_halted = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_ops();
        test_backpressure();
        test_random_program(0,  0,  255);
        test_random_program(84, 0,  255);
        test_random_program(0,  84, 255);
        test_random_program(38, 38, 255);
        test_halt();

        // let any stray result show up before judging
        repeat (40) @(posedge i_clk);
        if (mismatches == 0 && exec_results_due.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
